[design/sha256_stream_hasher_top_macros.svh]
// Assertion macros used by the hasher top module.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sha_pkg.sv]
package sha_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ZERO,
		ST_LEN,
		ST_RUN,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} rnd_ctl_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

endpackage

[design/sha256_stream_hasher_top.sv]
// Channel   Dir  tdata bits                   tuser/tlast
// s_axis    in   [7:0] data_byte              tuser byte_valid, tlast end_of_message
// m_axis    out  [31:0] digest_word           tuser word_index, tlast last_word
// Bytes are taken one per cycle while idle; each full block is then compressed by the round unit.
// End of message pads one byte per cycle to 64, then compresses; a second
// block is needed when fewer than nine bytes remain. Eight digest words follow.
// Input is not ready while padding, compressing or emitting; output stalls hold.
// Reset is asynchronous and restores the initial hash.
module sha256_stream_hasher_top import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // byte_valid
	input  logic        s_axis_tlast,  // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // digest_word
	output logic [2:0]  m_axis_tuser,  // word_index
	output logic        m_axis_tlast   // last_word
);

`include "sha256_stream_hasher_top_macros.svh"

	ctl_state_t  state_q, state_d;
	logic [31:0] mem_q [16];
	logic [5:0]  fill_q;
	logic [63:0] len_q, lenlat_q;
	logic        eom_q;
	logic        final_q;
	logic        padded_q;
	logic [2:0]  idx_q;
	logic [3:0]  word_addr;
	logic        rdone;
	logic [31:0] hash_word [8];
	rnd_ctl_t    rctl;
	logic        acc;
	logic        wr_en;
	logic [5:0]  wr_addr;
	logic [7:0]  wr_data;
	logic [31:0] blk_word;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign blk_word = mem_q[word_addr];
	assign m_axis_tvalid = (state_q == ST_EMIT);
	assign m_axis_tdata = hash_word[idx_q];
	assign m_axis_tuser = idx_q;
	assign m_axis_tlast = (idx_q == 3'd7);

	always_comb begin
		state_d = state_q;
		rctl = '0;
		rctl.busy = (state_q == ST_RUN);
		wr_en = 1'b0;
		wr_addr = fill_q;
		wr_data = s_axis_tdata;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && s_axis_tuser) begin
					wr_en = 1'b1;
					if (fill_q == 6'd63) begin
						rctl.start = 1'b1;
						state_d = ST_RUN;
					end else if (s_axis_tlast) begin
						state_d = ST_PAD;
					end
				end else if (acc && s_axis_tlast) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				wr_en = 1'b1;
				wr_data = PAD_BYTE;
				if (fill_q == 6'd63) begin
					rctl.start = 1'b1;
					state_d = ST_RUN;
				end else begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				wr_en = 1'b1;
				wr_data = 8'h00;
				if (final_q && fill_q == LEN_POS) begin
					wr_data = lenlat_q[63:56];
					state_d = ST_LEN;
				end else if (fill_q == 6'd63) begin
					rctl.start = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_LEN: begin
				wr_en = 1'b1;
				wr_data = lenlat_q[8'(7'd63 - {fill_q[2:0], 3'd0}) -: 8];
				if (fill_q == 6'd63) begin
					rctl.start = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (rdone) begin
					if (!eom_q) begin
						state_d = ST_IDLE;
					end else if (final_q) begin
						state_d = ST_EMIT;
					end else if (padded_q) begin
						state_d = ST_ZERO;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_EMIT: begin
				if (m_axis_tready && idx_q == 3'd7) begin
					rctl.done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			len_q <= '0;
			lenlat_q <= '0;
			eom_q <= 1'b0;
			final_q <= 1'b0;
			padded_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (state_q == ST_IDLE && acc) begin
				eom_q <= s_axis_tlast;
				lenlat_q <= len_q + (s_axis_tuser ? 64'd8 : 64'd0);
				len_q <= len_q + (s_axis_tuser ? 64'd8 : 64'd0);
				final_q <= s_axis_tlast && !(s_axis_tuser && fill_q == 6'd63)
					&& (fill_q + {5'd0, s_axis_tuser}) < 6'd56;
			end
			if (state_q == ST_PAD) begin
				padded_q <= 1'b1;
			end
			if (state_q == ST_RUN && rdone && eom_q && !final_q) begin
				final_q <= 1'b1;
			end
			if (state_q == ST_EMIT && m_axis_tready) begin
				idx_q <= idx_q + 3'd1;
			end
			if (rctl.done) begin
				len_q <= '0;
				eom_q <= 1'b0;
				final_q <= 1'b0;
				padded_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[5:2]][{~wr_addr[1:0], 3'd0} +: 8] <= wr_data;
		end
	end

	sha_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (rctl),
		.blk_word  (blk_word),
		.word_addr (word_addr),
		.done      (rdone),
		.hash_word (hash_word)
	);

	`SHA_ASSERT_IMP(a_no_ready_emit, m_axis_tvalid, !s_axis_tready, "ready while emitting")
	`SHA_ASSERT_IMP(a_done_in_run, rdone, state_q == ST_RUN, "round done outside run")
	`SHA_ASSERT_NEXT(a_start_run, rctl.start, state_q == ST_RUN, "start without run")
	`SHA_ASSERT_IMP(a_fill_zero_emit, m_axis_tvalid, fill_q == 6'd0, "fill not empty at emit")

endmodule

[design/sha_round.sv]
module sha_round import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rnd_ctl_t    ctl_in,
	input  logic [31:0] blk_word,
	output logic [3:0]  word_addr,
	output logic        done,
	output logic [31:0] hash_word [8]
);

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        fin_q;
	logic [5:0]  t;
	logic [31:0] w, w2, w15, s0, s1, t1, t2, a, e;

	assign t = cnt_q[5:0];
	assign word_addr = t[3:0];
	assign done = fin_q;
	assign hash_word = h_q;

	always_comb begin
		w2 = w_q[4'(t - 6'd2)];
		w15 = w_q[4'(t - 6'd15)];
		s1 = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
		s0 = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
		if (t < 6'd16) begin
			w = blk_word;
		end else begin
			w = s1 + w_q[4'(t - 6'd7)] + s0 + w_q[t[3:0]];
		end
		a = v_q[0];
		e = v_q[4];
		t1 = v_q[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + RK[t] + w;
		t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
			h_q <= IV;
		end else begin
			fin_q <= 1'b0;
			if (ctl_in.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				v_q <= h_q;
			end else if (run_q) begin
				w_q[t[3:0]] <= w;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
				cnt_q <= cnt_q + 7'd1;
				if (t == 6'd63) begin
					run_q <= 1'b0;
				end
			end else if (cnt_q == 7'd64) begin
				for (int j = 0; j < 8; j++) begin
					h_q[j] <= h_q[j] + v_q[j];
				end
				cnt_q <= '0;
				fin_q <= 1'b1;
			end else if (ctl_in.done) begin
				h_q <= IV;
			end
		end
	end

endmodule
